### rtl/pedestrian_zone_warning_classifier_defines.svh
// assertion macros for the pedestrian zone warning classifier
`ifndef PEDESTRIAN_ZONE_WARNING_CLASSIFIER_DEFINES_SVH
`define PEDESTRIAN_ZONE_WARNING_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PZWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define PZWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pzwc_pkg.sv
// shared constants for the pedestrian zone warning classifier
package pzwc_pkg;

    localparam int unsigned LEVEL_W = 2;

    localparam logic [LEVEL_W-1:0] LVL_SAFE    = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_WARNING = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CAUTION = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_STOP    = 2'd3;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_V01    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_V23    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAUTION_V01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAUTION_V23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_V01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_V23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PED_CLASS   = 3'd6;

    localparam int unsigned CLASS_W = 8;

    localparam logic [CLASS_W-1:0] PED_CLASS_RST = 8'd7;

    // default zone vertices, x0 y0 x1 y1 x2 y2 x3 y3
    localparam logic [15:0] STOP_RST [8] =
        '{16'd50, 16'd1080, 16'd200, 16'd900, 16'd610, 16'd900, 16'd760, 16'd1080};
    localparam logic [15:0] CAUTION_RST [8] =
        '{16'd50, 16'd1080, 16'd280, 16'd700, 16'd530, 16'd700, 16'd760, 16'd1080};
    localparam logic [15:0] WARNING_RST [8] =
        '{16'd50, 16'd1080, 16'd330, 16'd550, 16'd480, 16'd550, 16'd760, 16'd1080};

endpackage

### rtl/pedestrian_zone_warning_classifier.sv
// top level: pedestrian foot point zone classifier with frame maximum
//
// channel  direction  handshake                 payload
// in       sink       i_in_valid / o_in_ready   object_valid .. frame_last
// out      source     o_out_valid / i_out_ready object_level, frame_level, frame_done
// cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled
// the result passes the foot point register and the zone multipliers into the result register
// synchronous active-low reset restores the default zones and clears the frame level
// a stalled output holds both stages; input ready drops only when both stages are full
`include "pedestrian_zone_warning_classifier_defines.svh"

module pedestrian_zone_warning_classifier import pzwc_pkg::*; #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [4*COORD_BITS-1:0] i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_object_valid,
    input  logic                    i_has_class,
    input  logic [CLASS_W-1:0]      i_class_label,
    input  logic [COORD_BITS-1:0]   i_box_x,
    input  logic [COORD_BITS-1:0]   i_box_y,
    input  logic [COORD_BITS-1:0]   i_box_width,
    input  logic [COORD_BITS-1:0]   i_box_height,
    input  logic                    i_frame_last,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [LEVEL_W-1:0]      o_object_level,
    output logic [LEVEL_W-1:0]      o_frame_level,
    output logic                    o_frame_done
);

    localparam int unsigned ZW = 4 * COORD_BITS;
    localparam int unsigned C  = COORD_BITS;

    localparam logic [ZW-1:0] STOP_V01_RST = {STOP_RST[3][C-1:0], STOP_RST[2][C-1:0],
                                              STOP_RST[1][C-1:0], STOP_RST[0][C-1:0]};
    localparam logic [ZW-1:0] STOP_V23_RST = {STOP_RST[7][C-1:0], STOP_RST[6][C-1:0],
                                              STOP_RST[5][C-1:0], STOP_RST[4][C-1:0]};
    localparam logic [ZW-1:0] CAUT_V01_RST = {CAUTION_RST[3][C-1:0], CAUTION_RST[2][C-1:0],
                                              CAUTION_RST[1][C-1:0], CAUTION_RST[0][C-1:0]};
    localparam logic [ZW-1:0] CAUT_V23_RST = {CAUTION_RST[7][C-1:0], CAUTION_RST[6][C-1:0],
                                              CAUTION_RST[5][C-1:0], CAUTION_RST[4][C-1:0]};
    localparam logic [ZW-1:0] WARN_V01_RST = {WARNING_RST[3][C-1:0], WARNING_RST[2][C-1:0],
                                              WARNING_RST[1][C-1:0], WARNING_RST[0][C-1:0]};
    localparam logic [ZW-1:0] WARN_V23_RST = {WARNING_RST[7][C-1:0], WARNING_RST[6][C-1:0],
                                              WARNING_RST[5][C-1:0], WARNING_RST[4][C-1:0]};

    logic [ZW-1:0]      r_stop_v01, r_stop_v23;
    logic [ZW-1:0]      r_caut_v01, r_caut_v23;
    logic [ZW-1:0]      r_warn_v01, r_warn_v23;
    logic [CLASS_W-1:0] r_ped_class;

    logic               r_s1_vld;
    logic               r_s1_obj;
    logic               r_s1_ped;
    logic               r_s1_last;
    logic [C:0]         r_s1_fx;
    logic [C:0]         r_s1_fy;

    logic               r_out_vld;
    logic [LEVEL_W-1:0] r_out_obj_lvl;
    logic [LEVEL_W-1:0] r_out_frm_lvl;
    logic               r_out_done;
    logic [LEVEL_W-1:0] r_run;

    logic               out_adv;
    logic               s1_adv;
    logic               in_xfer;
    logic               s1_to_out;
    logic               in_stop, in_caut, in_warn;
    logic [LEVEL_W-1:0] zone_lvl;
    logic [LEVEL_W-1:0] n_obj_lvl;
    logic [LEVEL_W-1:0] n_frm_lvl;
    logic               n_done;
    logic [LEVEL_W-1:0] n_run;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_v01  <= STOP_V01_RST;
            r_stop_v23  <= STOP_V23_RST;
            r_caut_v01  <= CAUT_V01_RST;
            r_caut_v23  <= CAUT_V23_RST;
            r_warn_v01  <= WARN_V01_RST;
            r_warn_v23  <= WARN_V23_RST;
            r_ped_class <= PED_CLASS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STOP_V01:    r_stop_v01  <= i_cfg_data;
                CFG_STOP_V23:    r_stop_v23  <= i_cfg_data;
                CFG_CAUTION_V01: r_caut_v01  <= i_cfg_data;
                CFG_CAUTION_V23: r_caut_v23  <= i_cfg_data;
                CFG_WARNING_V01: r_warn_v01  <= i_cfg_data;
                CFG_WARNING_V23: r_warn_v23  <= i_cfg_data;
                CFG_PED_CLASS:   r_ped_class <= i_cfg_data[CLASS_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_adv    = !r_out_vld || i_out_ready;
    assign s1_adv     = !r_s1_vld || out_adv;
    assign o_in_ready = s1_adv;
    assign in_xfer    = i_in_valid && s1_adv;
    assign s1_to_out  = r_s1_vld && out_adv;

    // stage 1: foot point and pedestrian match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_obj  <= i_object_valid;
            r_s1_ped  <= i_has_class && (i_class_label == r_ped_class);
            r_s1_last <= i_frame_last;
            r_s1_fx   <= {1'b0, i_box_x} + {2'b00, i_box_width[C-1:1]};
            r_s1_fy   <= {1'b0, i_box_y} + {1'b0, i_box_height};
        end
    end

    pzwc_zone_test #(.COORD_BITS(COORD_BITS)) u_stop (
        .i_zone_lo (r_stop_v01),
        .i_zone_hi (r_stop_v23),
        .i_px      (r_s1_fx),
        .i_py      (r_s1_fy),
        .o_inside  (in_stop)
    );

    pzwc_zone_test #(.COORD_BITS(COORD_BITS)) u_caution (
        .i_zone_lo (r_caut_v01),
        .i_zone_hi (r_caut_v23),
        .i_px      (r_s1_fx),
        .i_py      (r_s1_fy),
        .o_inside  (in_caut)
    );

    pzwc_zone_test #(.COORD_BITS(COORD_BITS)) u_warning (
        .i_zone_lo (r_warn_v01),
        .i_zone_hi (r_warn_v23),
        .i_px      (r_s1_fx),
        .i_py      (r_s1_fy),
        .o_inside  (in_warn)
    );

    // zone priority and frame maximum
    always_comb begin
        if (in_stop) begin
            zone_lvl = LVL_STOP;
        end else if (in_caut) begin
            zone_lvl = LVL_CAUTION;
        end else if (in_warn) begin
            zone_lvl = LVL_WARNING;
        end else begin
            zone_lvl = LVL_SAFE;
        end

        if (!r_s1_obj) begin
            n_obj_lvl = LVL_SAFE;
            n_frm_lvl = r_run;
            n_done    = 1'b1;
        end else begin
            n_obj_lvl = r_s1_ped ? zone_lvl : LVL_SAFE;
            n_frm_lvl = (n_obj_lvl > r_run) ? n_obj_lvl : r_run;
            n_done    = r_s1_last;
        end

        n_run = n_done ? LVL_SAFE : n_frm_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_run     <= LVL_SAFE;
        end else begin
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_to_out) begin
                r_run <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_to_out) begin
            r_out_obj_lvl <= n_obj_lvl;
            r_out_frm_lvl <= n_frm_lvl;
            r_out_done    <= n_done;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_object_level = r_out_obj_lvl;
    assign o_frame_level  = r_out_frm_lvl;
    assign o_frame_done   = r_out_done;

    `PZWC_ASSERT_NOW(a_frame_ge_object, i_clk, i_rst_n, r_out_vld, r_out_frm_lvl >= r_out_obj_lvl, "frame level below object level")
    `PZWC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_out_vld, o_in_ready, "input stalled with empty output register")
    `PZWC_ASSERT_NEXT(a_empty_item_closes, i_clk, i_rst_n, s1_to_out && !r_s1_obj, (r_run == LVL_SAFE) && r_out_done && (r_out_obj_lvl == LVL_SAFE), "empty item did not close the frame")

endmodule

### rtl/pzwc_zone_test.sv
// point in quadrilateral test, edge points count as inside
module pzwc_zone_test import pzwc_pkg::*; #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic [4*COORD_BITS-1:0] i_zone_lo,
    input  logic [4*COORD_BITS-1:0] i_zone_hi,
    input  logic [COORD_BITS:0]     i_px,
    input  logic [COORD_BITS:0]     i_py,
    output logic                    o_inside
);

    localparam int unsigned DW = COORD_BITS + 2;
    localparam int unsigned PW = 2 * DW;

    logic signed [DW-1:0] vx [4];
    logic signed [DW-1:0] vy [4];
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic [3:0]           edge_on;
    logic [3:0]           edge_cross;

    assign vx[0] = signed'({2'b00, i_zone_lo[COORD_BITS-1:0]});
    assign vy[0] = signed'({2'b00, i_zone_lo[2*COORD_BITS-1:COORD_BITS]});
    assign vx[1] = signed'({2'b00, i_zone_lo[3*COORD_BITS-1:2*COORD_BITS]});
    assign vy[1] = signed'({2'b00, i_zone_lo[4*COORD_BITS-1:3*COORD_BITS]});
    assign vx[2] = signed'({2'b00, i_zone_hi[COORD_BITS-1:0]});
    assign vy[2] = signed'({2'b00, i_zone_hi[2*COORD_BITS-1:COORD_BITS]});
    assign vx[3] = signed'({2'b00, i_zone_hi[3*COORD_BITS-1:2*COORD_BITS]});
    assign vy[3] = signed'({2'b00, i_zone_hi[4*COORD_BITS-1:3*COORD_BITS]});
    assign px    = signed'({1'b0, i_px});
    assign py    = signed'({1'b0, i_py});

    for (genvar g = 0; g < 4; g++) begin : g_edge
        localparam int unsigned A = (g + 3) % 4;

        logic signed [DW-1:0] ax, ay, bx, by;
        logic signed [PW-1:0] m_y, m_x, d;
        logic                 skip;

        assign ax = vx[A];
        assign ay = vy[A];
        assign bx = vx[g];
        assign by = vy[g];

        assign skip = ((ay <= py) && (by <= py)) || ((ay > py) && (by > py)) ||
                      ((ax < px) && (bx < px));

        assign m_y = PW'(py - ay) * PW'(bx - ax);
        assign m_x = PW'(px - ax) * PW'(by - ay);
        assign d   = m_y - m_x;

        always_comb begin
            if (skip) begin
                edge_on[g] = (py == by) && ((px == bx) || ((py == ay) &&
                             (((ax <= px) && (px <= bx)) || ((bx <= px) && (px <= ax)))));
                edge_cross[g] = 1'b0;
            end else begin
                edge_on[g]    = (d == '0);
                edge_cross[g] = (by < ay) ? (d < 0) : (d > 0);
            end
        end
    end

    assign o_inside = (|edge_on) || (^edge_cross);

endmodule

### dv/tb_top.sv
// self-checking testbench for the pedestrian zone warning classifier
`timescale 1ns / 100ps

module tb_top;
    import pzwc_pkg::*;

    localparam int unsigned CB = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int unsigned ITEMS_PER_PHASE = 135;
    localparam int unsigned NUM_PHASES = 8;

    typedef struct packed {
        logic [LEVEL_W-1:0] obj;
        logic [LEVEL_W-1:0] frm;
        logic               done;
    } t_level_res;

    typedef struct packed {
        logic               ov;
        logic               hc;
        logic [CLASS_W-1:0] lbl;
        logic [CB-1:0]      bx;
        logic [CB-1:0]      by;
        logic [CB-1:0]      bw;
        logic [CB-1:0]      bh;
        logic               last;
        logic               typed;
        logic [LEVEL_W-1:0] e_obj;
        logic [LEVEL_W-1:0] e_frm;
        logic               e_done;
    } t_det_obj;

    localparam t_det_obj DIRECTED_OBJS [18] = '{
        '{1'b0, 1'b0, 8'd0,   12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b1,
          LVL_SAFE, LVL_SAFE, 1'b1},
        '{1'b1, 1'b1, 8'd7,   12'd400,  12'd900,  12'd10,   12'd100,  1'b0, 1'b1,
          LVL_STOP, LVL_STOP, 1'b0},
        '{1'b1, 1'b1, 8'd8,   12'd400,  12'd900,  12'd10,   12'd100,  1'b1, 1'b1,
          LVL_SAFE, LVL_STOP, 1'b1},
        '{1'b1, 1'b0, 8'd7,   12'd400,  12'd900,  12'd10,   12'd100,  1'b0, 1'b1,
          LVL_SAFE, LVL_SAFE, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd405,  12'd700,  12'd0,    12'd100,  1'b0, 1'b1,
          LVL_CAUTION, LVL_CAUTION, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd405,  12'd500,  12'd0,    12'd100,  1'b0, 1'b1,
          LVL_WARNING, LVL_CAUTION, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd405,  12'd400,  12'd0,    12'd100,  1'b1, 1'b1,
          LVL_SAFE, LVL_CAUTION, 1'b1},
        '{1'b1, 1'b1, 8'd7,   12'd50,   12'd1080, 12'd0,    12'd0,    1'b0, 1'b1,
          LVL_STOP, LVL_STOP, 1'b0},
        '{1'b0, 1'b0, 8'd0,   12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 1'b1,
          LVL_SAFE, LVL_STOP, 1'b1},
        '{1'b1, 1'b1, 8'd7,   12'd400,  12'd1000, 12'd0,    12'd80,   1'b0, 1'b0,
          LVL_SAFE, LVL_SAFE, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd405,  12'd800,  12'd0,    12'd100,  1'b0, 1'b0,
          LVL_SAFE, LVL_SAFE, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd125,  12'd990,  12'd0,    12'd0,    1'b0, 1'b0,
          LVL_SAFE, LVL_SAFE, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd124,  12'd990,  12'd0,    12'd0,    1'b0, 1'b0,
          LVL_SAFE, LVL_SAFE, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b0,
          LVL_SAFE, LVL_SAFE, 1'b0},
        '{1'b1, 1'b1, 8'd7,   12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 1'b1,
          LVL_SAFE, LVL_SAFE, 1'b1},
        '{1'b1, 1'b1, 8'd255, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1,
          LVL_SAFE, LVL_SAFE, 1'b1},
        '{1'b0, 1'b1, 8'd255, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1,
          LVL_SAFE, LVL_SAFE, 1'b1},
        '{1'b1, 1'b1, 8'd7,   12'd400,  12'd900,  12'd11,   12'd100,  1'b1, 1'b0,
          LVL_SAFE, LVL_SAFE, 1'b0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [4*CB-1:0]      i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_object_valid;
    logic                 i_has_class;
    logic [CLASS_W-1:0]   i_class_label;
    logic [CB-1:0]        i_box_x;
    logic [CB-1:0]        i_box_y;
    logic [CB-1:0]        i_box_width;
    logic [CB-1:0]        i_box_height;
    logic                 i_frame_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [LEVEL_W-1:0]   o_object_level;
    logic [LEVEL_W-1:0]   o_frame_level;
    logic                 o_frame_done;

    logic [4*CB-1:0]    zone_reg [6];
    logic [CLASS_W-1:0] ped_class;
    logic [LEVEL_W-1:0] frame_max;
    t_level_res         pending_levels [$];
    int                 accepted_items = 0;
    int                 error_count = 0;
    int                 sender_idle_pct = 0;
    int                 sink_stall_pct = 0;
    logic               cur_typed = 1'b0;
    t_level_res         cur_exp = '0;

    pedestrian_zone_warning_classifier i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [4*CB-1:0] pack_vertices(logic [15:0] x0, logic [15:0] y0,
                                                      logic [15:0] x1, logic [15:0] y1);
        return {y1[CB-1:0], x1[CB-1:0], y0[CB-1:0], x0[CB-1:0]};
    endfunction

    // inside or on the boundary, even-odd crossing count for the rest
    function automatic bit point_in_zone(logic [4*CB-1:0] lo, logic [4*CB-1:0] hi,
                                         longint px, longint py);
        longint vx [4];
        longint vy [4];
        longint ax, ay, bx, by, d;
        int     crossings;
        vx[0] = longint'(lo[11:0]);  vy[0] = longint'(lo[23:12]);
        vx[1] = longint'(lo[35:24]); vy[1] = longint'(lo[47:36]);
        vx[2] = longint'(hi[11:0]);  vy[2] = longint'(hi[23:12]);
        vx[3] = longint'(hi[35:24]); vy[3] = longint'(hi[47:36]);
        crossings = 0;
        ax = vx[3];
        ay = vy[3];
        for (int i = 0; i < 4; i++) begin
            bx = vx[i];
            by = vy[i];
            if ((ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px)) begin
                if (py == by && (px == bx || (py == ay &&
                    ((ax <= px && px <= bx) || (bx <= px && px <= ax)))))
                    return 1'b1;
            end else begin
                d = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
                if (d == 0)
                    return 1'b1;
                if (by < ay)
                    d = -d;
                if (d > 0)
                    crossings++;
            end
            ax = bx;
            ay = by;
        end
        return crossings[0];
    endfunction

    function automatic logic [LEVEL_W-1:0] foot_level(longint fx, longint fy);
        if (point_in_zone(zone_reg[CFG_STOP_V01], zone_reg[CFG_STOP_V23], fx, fy))
            return LVL_STOP;
        if (point_in_zone(zone_reg[CFG_CAUTION_V01], zone_reg[CFG_CAUTION_V23], fx, fy))
            return LVL_CAUTION;
        if (point_in_zone(zone_reg[CFG_WARNING_V01], zone_reg[CFG_WARNING_V23], fx, fy))
            return LVL_WARNING;
        return LVL_SAFE;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // expected levels, result checking and register shadow
    always @(posedge i_clk) begin
        t_level_res want;
        t_level_res calc;
        longint     fx, fy;
        if (!i_rst_n) begin
            zone_reg[CFG_STOP_V01]    = pack_vertices(STOP_RST[0], STOP_RST[1],
                                                      STOP_RST[2], STOP_RST[3]);
            zone_reg[CFG_STOP_V23]    = pack_vertices(STOP_RST[4], STOP_RST[5],
                                                      STOP_RST[6], STOP_RST[7]);
            zone_reg[CFG_CAUTION_V01] = pack_vertices(CAUTION_RST[0], CAUTION_RST[1],
                                                      CAUTION_RST[2], CAUTION_RST[3]);
            zone_reg[CFG_CAUTION_V23] = pack_vertices(CAUTION_RST[4], CAUTION_RST[5],
                                                      CAUTION_RST[6], CAUTION_RST[7]);
            zone_reg[CFG_WARNING_V01] = pack_vertices(WARNING_RST[0], WARNING_RST[1],
                                                      WARNING_RST[2], WARNING_RST[3]);
            zone_reg[CFG_WARNING_V23] = pack_vertices(WARNING_RST[4], WARNING_RST[5],
                                                      WARNING_RST[6], WARNING_RST[7]);
            ped_class = PED_CLASS_RST;
            frame_max = LVL_SAFE;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_levels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, o_object_level, o_frame_level, o_frame_done);
                    error_count++;
                end else begin
                    want = pending_levels.pop_front();
                    check_field("object_level", want.obj, o_object_level);
                    check_field("frame_level", want.frm, o_frame_level);
                    check_field("frame_done", want.done, o_frame_done);
                end
            end
            if (i_in_valid && o_in_ready) begin
                calc.obj = LVL_SAFE;
                if (!i_object_valid) begin
                    calc.frm  = frame_max;
                    calc.done = 1'b1;
                end else begin
                    if (i_has_class && i_class_label == ped_class) begin
                        fx = longint'(i_box_x) + longint'(i_box_width >> 1);
                        fy = longint'(i_box_y) + longint'(i_box_height);
                        calc.obj = foot_level(fx, fy);
                    end
                    if (calc.obj > frame_max)
                        frame_max = calc.obj;
                    calc.frm  = frame_max;
                    calc.done = i_frame_last;
                end
                if (calc.done)
                    frame_max = LVL_SAFE;
                pending_levels = {pending_levels, (cur_typed ? cur_exp : calc)};
                accepted_items++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STOP_V01, CFG_STOP_V23, CFG_CAUTION_V01, CFG_CAUTION_V23,
                    CFG_WARNING_V01, CFG_WARNING_V23: zone_reg[i_cfg_index] = i_cfg_data;
                    CFG_PED_CLASS: ped_class = i_cfg_data[CLASS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic send_obj(t_det_obj it);
        int target;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_object_valid <= it.ov;
        i_has_class    <= it.hc;
        i_class_label  <= it.lbl;
        i_box_x        <= it.bx;
        i_box_y        <= it.by;
        i_box_width    <= it.bw;
        i_box_height   <= it.bh;
        i_frame_last   <= it.last;
        cur_typed      = it.typed;
        cur_exp        = '{it.e_obj, it.e_frm, it.e_done};
        i_in_valid     <= 1'b1;
        target = accepted_items + 1;
        do @(negedge i_clk); while (accepted_items != target);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending_levels.size() != 0);
    endtask

    // mostly foot points on or near a zone's vertices, edges and bounding box
    task automatic send_random();
        t_det_obj it;
        int       z, k, k2, pick, tx, ty, w, h;
        int       vx [4];
        int       vy [4];
        int       lo_x, hi_x, lo_y, hi_y;
        it = '0;
        it.ov   = ($urandom_range(0, 99) < 95);
        it.last = ($urandom_range(0, 99) < 25);
        if ($urandom_range(0, 99) < 75) begin
            it.hc  = ($urandom_range(0, 19) != 0);
            it.lbl = ped_class;
        end else begin
            it.hc  = 1'($urandom);
            it.lbl = 8'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.bx = 12'($urandom);
            it.by = 12'($urandom);
            it.bw = 12'($urandom);
            it.bh = 12'($urandom);
        end else begin
            z = $urandom_range(0, 2);
            for (int i = 0; i < 2; i++) begin
                vx[2*i]   = int'(zone_reg[2*z+i][11:0]);
                vy[2*i]   = int'(zone_reg[2*z+i][23:12]);
                vx[2*i+1] = int'(zone_reg[2*z+i][35:24]);
                vy[2*i+1] = int'(zone_reg[2*z+i][47:36]);
            end
            k  = $urandom_range(0, 3);
            k2 = (k + 1) % 4;
            if (pick < 30) begin
                tx = vx[k];
                ty = vy[k];
            end else if (pick < 50) begin
                tx = $urandom_range(vx[k], vx[k2]);
                ty = $urandom_range(0, 1) ? vy[k] : vy[k2];
            end else begin
                lo_x = 4095; hi_x = 0; lo_y = 4095; hi_y = 0;
                for (int i = 0; i < 4; i++) begin
                    if (vx[i] < lo_x) lo_x = vx[i];
                    if (vx[i] > hi_x) hi_x = vx[i];
                    if (vy[i] < lo_y) lo_y = vy[i];
                    if (vy[i] > hi_y) hi_y = vy[i];
                end
                tx = $urandom_range(hi_x + 2, (lo_x > 2) ? lo_x - 2 : 0);
                ty = $urandom_range(hi_y + 2, (lo_y > 2) ? lo_y - 2 : 0);
                if (tx > 4095) tx = 4095;
                if (ty > 4095) ty = 4095;
            end
            w = $urandom_range(0, (2 * tx + 1 > 4095) ? 4095 : 2 * tx + 1);
            h = $urandom_range(0, ty);
            it.bx = 12'(tx - w / 2);
            it.bw = 12'(w);
            it.by = 12'(ty - h);
            it.bh = 12'(h);
        end
        send_obj(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4*CB-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    task automatic load_setting(int phase);
        logic [4*CB-1:0] junk;
        int              span;
        junk = {$urandom, $urandom};
        case (phase)
            1: begin
                for (int r = CFG_STOP_V01; r <= CFG_WARNING_V23; r++)
                    write_reg(3'(r), zone_reg[r]);
                write_reg(CFG_PED_CLASS, {junk[4*CB-1:CLASS_W], PED_CLASS_RST});
            end
            4: begin
                for (int r = CFG_STOP_V01; r <= CFG_WARNING_V23; r++)
                    write_reg(3'(r), '0);
                write_reg(CFG_PED_CLASS, '0);
            end
            5: begin
                for (int r = CFG_STOP_V01; r <= CFG_WARNING_V23; r++)
                    write_reg(3'(r), '1);
                write_reg(CFG_PED_CLASS, '1);
            end
            default: begin
                span = (phase == 2) ? 4095 : (phase == 3) ? 31 : (phase == 6) ? 15 : 63;
                for (int r = CFG_STOP_V01; r <= CFG_WARNING_V23; r++)
                    write_reg(3'(r), pack_vertices(16'($urandom_range(0, span)),
                                                   16'($urandom_range(0, span)),
                                                   16'($urandom_range(0, span)),
                                                   16'($urandom_range(0, span))));
                write_reg(CFG_PED_CLASS, junk);
                if (phase == 6)
                    write_reg(CFG_UNUSED, {$urandom, $urandom});
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_STOP_V01;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_object_valid = 1'b0;
        i_has_class    = 1'b0;
        i_class_label  = '0;
        i_box_x        = '0;
        i_box_y        = '0;
        i_box_width    = '0;
        i_box_height   = '0;
        i_frame_last   = 1'b0;
        i_out_ready    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_OBJS[n])
            send_obj(DIRECTED_OBJS[n]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            if (p != 0)
                load_setting(p);
            sender_idle_pct = (p % 4 == 1) ? 83 : (p % 4 == 3) ? 25 : 0;
            sink_stall_pct  = (p % 4 == 2) ? 83 : (p % 4 == 3) ? 25 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender holds off until every result is back
                if (p == 1 && n == 60) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                send_random();
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pzwc_pkg.sv
rtl/pzwc_zone_test.sv
rtl/pedestrian_zone_warning_classifier.sv
dv/tb_top.sv
